// ===== src/bdq_pkg.sv =====
// bdq_pkg: shared types and constants for the bounded deque with search
// depends on nothing; imported by dq cells and the top level
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4,
		OP_DUMP       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_PREV,
		CELL_FROM_NEXT,
		CELL_FROM_HEAD
	} cell_cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WALK
	} fsm_t;

endpackage

`default_nettype wire

// ===== src/bdq_cell.sv =====
// bdq_cell: one storage cell of the deque chain
// depends on bdq_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell
	import bdq_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] value,
	input  wire logic [DATA_W-1:0] prev_d,
	input  wire logic [DATA_W-1:0] next_d,
	input  wire logic [DATA_W-1:0] head_d,
	output logic      [DATA_W-1:0] q
);

	logic [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_HOLD:      entry_q <= entry_q;
			CELL_LOAD:      entry_q <= value;
			CELL_FROM_PREV: entry_q <= prev_d;
			CELL_FROM_NEXT: entry_q <= next_d;
			CELL_FROM_HEAD: entry_q <= head_d;
			default:        entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

`default_nettype wire

// ===== src/bounded_deque_with_search_core.sv =====
// bounded_deque_with_search_core: bounded deque in a chain of cells with linear search
// depends on bdq_pkg and bdq_cell
//
// channel   | signals                                  | handshake
// ----------+------------------------------------------+---------------------------------
// command   | operation[2:0], value[31:0]              | taken when start && !busy
// result    | status, data, position, entries, last    | strobe for one cycle, no stall
//
// push and pop results appear the cycle after the item is taken, and the next item
//   may come at once
// search and dump walk the occupied cells, one per cycle, by rotating the chain;
//   busy stays high while the walk visits the entries (up to DEPTH)
// an empty search or dump answers with status empty and starts no walk
// reset clears the count and the walk control; cell contents stay undefined
// the receiver cannot stall: every strobed result is taken in its cycle
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_search_core
	import bdq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         operation,
	input  wire logic signed [31:0] value,
	output logic                    strobe,
	output logic [1:0]              status,
	output logic signed [31:0]      data,
	output logic [4:0]              position,
	output logic [4:0]              entries,
	output logic                    last
);

	// cell 0 holds the front entry, except while a walk rotates the chain
	logic      [DATA_W-1:0] cell_q   [DEPTH];
	cell_cmd_t              cell_cmd [DEPTH];

	fsm_t             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] walk_cnt_q;
	logic             walk_dump_q;
	logic             found_q;
	logic [DATA_W-1:0] key_q;

	logic             accept;
	op_t              op;
	logic             full;
	logic             empty;
	logic             walk_last;
	logic             head_match;
	logic [CNT_W-1:0] count_m1;

	// next result
	logic              res_strobe_d;
	status_t           res_status_d;
	logic [DATA_W-1:0] res_data_d;
	logic [CNT_W-1:0]  res_pos_d;
	logic              res_last_d;

	logic              strobe_q;
	status_t           status_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  entries_q;
	logic              last_q;

	assign accept     = start && (state_q == FSM_IDLE);
	assign op         = op_t'(operation);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign empty      = (count_q == '0);
	assign count_m1   = count_q - CNT_W'(1);
	assign walk_last  = ({1'b0, walk_cnt_q} == count_m1);
	assign head_match = (cell_q[0] == key_q);

	// the chain of cells, wired as a ring
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		bdq_cell u_cell (
			.clk    (clk),
			.cmd    (cell_cmd[g]),
			.value  (value),
			.prev_d (cell_q[(g + DEPTH - 1) % DEPTH]),
			.next_d (cell_q[(g + 1) % DEPTH]),
			.head_d (cell_q[0]),
			.q      (cell_q[g])
		);
	end

	// per-cell command decode
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_cmd[i] = CELL_HOLD;
			if (state_q == FSM_WALK) begin
				// rotate the occupied part: front moves to the back
				if (CNT_W'(i) < count_m1)
					cell_cmd[i] = CELL_FROM_NEXT;
				else if (CNT_W'(i) == count_m1)
					cell_cmd[i] = CELL_FROM_HEAD;
			end else if (accept) begin
				unique case (op)
					OP_PUSH_FRONT: if (!full) begin
						cell_cmd[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
					end
					OP_PUSH_BACK: if (!full && CNT_W'(i) == count_q) begin
						cell_cmd[i] = CELL_LOAD;
					end
					OP_POP_FRONT: if (!empty) begin
						cell_cmd[i] = CELL_FROM_NEXT;
					end
					default: cell_cmd[i] = CELL_HOLD;
				endcase
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (accept && !empty && (op == OP_SEARCH || op == OP_DUMP)) begin
				state_d = FSM_WALK;
			end
			FSM_WALK: if (walk_last) begin
				state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// next count
	always_comb begin
		count_d = count_q;
		if (accept) begin
			unique case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: if (!full) begin
					count_d = count_q + CNT_W'(1);
				end
				OP_POP_FRONT, OP_POP_BACK: if (!empty) begin
					count_d = count_m1;
				end
				default: count_d = count_q;
			endcase
		end
	end

	// result outputs
	always_comb begin
		res_strobe_d = 1'b0;
		res_status_d = ST_OK;
		res_data_d   = '0;
		res_pos_d    = '0;
		res_last_d   = 1'b1;
		unique case (state_q)
			FSM_WALK: begin
				if (walk_dump_q) begin
					res_strobe_d = 1'b1;
					res_data_d   = cell_q[0];
					res_last_d   = walk_last;
				end else if (!found_q && head_match) begin
					res_strobe_d = 1'b1;
					res_pos_d    = {1'b0, walk_cnt_q} + CNT_W'(1);
				end else if (!found_q && walk_last) begin
					res_strobe_d = 1'b1;
					res_status_d = ST_NOTFOUND;
				end
			end
			FSM_IDLE: if (accept) begin
				unique case (op)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						res_strobe_d = 1'b1;
						res_status_d = full ? ST_FULL : ST_OK;
					end
					OP_POP_FRONT: begin
						res_strobe_d = 1'b1;
						res_status_d = empty ? ST_EMPTY : ST_OK;
						res_data_d   = empty ? '0 : cell_q[0];
					end
					OP_POP_BACK: begin
						res_strobe_d = 1'b1;
						res_status_d = empty ? ST_EMPTY : ST_OK;
						res_data_d   = empty ? '0 : cell_q[count_m1[IDX_W-1:0]];
					end
					OP_SEARCH, OP_DUMP: if (empty) begin
						res_strobe_d = 1'b1;
						res_status_d = ST_EMPTY;
					end
					default: res_strobe_d = 1'b0;
				endcase
			end
			default: res_strobe_d = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			count_q    <= '0;
			walk_cnt_q <= '0;
			found_q    <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= res_strobe_d;
			if (state_q == FSM_WALK) begin
				walk_cnt_q <= walk_cnt_q + IDX_W'(1);
				if (!walk_dump_q && head_match)
					found_q <= 1'b1;
			end else begin
				walk_cnt_q <= '0;
				found_q    <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= value;
			walk_dump_q <= (op == OP_DUMP);
		end
		status_q  <= res_status_d;
		data_q    <= res_data_d;
		pos_q     <= res_pos_d;
		entries_q <= count_d;
		last_q    <= res_last_d;
	end

	assign busy     = (state_q == FSM_WALK);
	assign strobe   = strobe_q;
	assign status   = status_q;
	assign data     = data_q;
	assign position = 5'(pos_q);
	assign entries  = 5'(entries_q);
	assign last     = last_q;

	// a walk only runs over a non-empty deque
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK) |-> (count_q != '0))
		else $error("walk over empty deque");

	// occupancy never exceeds the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	// occupancy moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
		else $error("occupancy jumped");

	// the occupancy is left alone during a walk
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK) |=> (count_q == $past(count_q)))
		else $error("occupancy changed during walk");

	// a search reports only its first match
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_WALK && !walk_dump_q && found_q) |=> !strobe)
		else $error("second search result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for bounded_deque_with_search_core
// depends on bdq_pkg and the core; predicts every result with its own deque model
`timescale 1ns / 1ps

module tb_top;
	import bdq_pkg::*;

	localparam int TOTAL_OPS = 260;  // stimulus stops once this many items are queued
	localparam int IDLE_LIMIT = 1000; // watchdog: cycles with no item and no result
	localparam int TAIL_CYCLES = 40;  // settle time after the last result

	// one command item as the driver presents it
	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] val;
		int                 gap;   // cycles to wait before presenting it
		logic               drain; // hold it until every expected result is in
	} op_item_t;

	// one predicted result
	typedef struct {
		status_t            status;
		logic signed [31:0] data;
		logic [4:0]         position;
		logic [4:0]         entries;
		logic               last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] operation = '0;
	logic signed [31:0] value = '0;
	logic busy;
	logic strobe;
	logic [1:0] status;
	logic signed [31:0] data;
	logic [4:0] position;
	logic [4:0] entries;
	logic last;

	op_item_t pending_ops[$];
	result_t expected_results[$];

	// predicted and checked results are counted apart so that the driver and
	// the monitor each own their counter; both update with nonblocking writes
	int predicted_cnt = 0;
	int checked_cnt = 0;
	int accepted_cnt = 0;
	int mismatches = 0;
	int total_items = 0;

	// deque model kept by the predictor
	logic signed [31:0] dq_mem[DEPTH];
	int dq_head = 0;
	int dq_count = 0;

	// stimulus generator state
	int gen_fill = 0;          // occupancy as the generator sees it
	logic ep_burst = 1'b0;     // back-to-back items for the current episode
	logic hold_next = 1'b0;    // next queued item waits for the results to drain
	logic signed [31:0] value_pool[8];

	bounded_deque_with_search_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operation(operation),
		.value    (value),
		.strobe   (strobe),
		.status   (status),
		.data     (data),
		.position (position),
		.entries  (entries),
		.last     (last)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	function automatic void add_result(status_t st, logic signed [31:0] d, int pos, logic fin);
		result_t r;
		r.status   = st;
		r.data     = d;
		r.position = 5'(pos);
		r.entries  = 5'(dq_count);
		r.last     = fin;
		expected_results.push_back(r);
	endfunction

	// applies one item to the deque model and queues what the block must emit;
	// returns how many results were queued
	function automatic int apply_deque_op(logic [2:0] op, logic signed [31:0] val);
		int i;
		int hit;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				// full queue: push dropped, state kept
				if (dq_count >= DEPTH) begin
					add_result(ST_FULL, '0, 0, 1'b1);
					return 1;
				end
				if (op == OP_PUSH_FRONT) begin
					dq_head = (dq_head + DEPTH - 1) % DEPTH;
					dq_mem[dq_head] = val;
				end else begin
					dq_mem[(dq_head + dq_count) % DEPTH] = val;
				end
				dq_count++;
				add_result(ST_OK, '0, 0, 1'b1);
				return 1;
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (dq_count == 0) begin
					add_result(ST_EMPTY, '0, 0, 1'b1);
					return 1;
				end
				dq_count--;
				if (op == OP_POP_FRONT) begin
					add_result(ST_OK, dq_mem[dq_head], 0, 1'b1);
					dq_head = (dq_head + 1) % DEPTH;
				end else begin
					add_result(ST_OK, dq_mem[(dq_head + dq_count) % DEPTH], 0, 1'b1);
				end
				return 1;
			end
			OP_SEARCH: begin
				if (dq_count == 0) begin
					add_result(ST_EMPTY, '0, 0, 1'b1);
					return 1;
				end
				// first match from the front, the back entry included
				hit = 0;
				for (i = 0; i < dq_count && hit == 0; i++)
					if (dq_mem[(dq_head + i) % DEPTH] == val)
						hit = i + 1;
				if (hit != 0)
					add_result(ST_OK, '0, hit, 1'b1);
				else
					add_result(ST_NOTFOUND, '0, 0, 1'b1);
				return 1;
			end
			OP_DUMP: begin
				if (dq_count == 0) begin
					add_result(ST_EMPTY, '0, 0, 1'b1);
					return 1;
				end
				for (i = 0; i < dq_count; i++)
					add_result(ST_OK, dq_mem[(dq_head + i) % DEPTH], 0, i + 1 == dq_count);
				return dq_count;
			end
			default: begin
				// undefined codes are ignored
				return 0;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// driver: presents queued items, predicts each one as it is taken
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : drive_ops
		int produced;
		int outstanding;
		int wait_left;
		logic wait_set;
		logic go;
		op_item_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			operation <= '0;
			value <= '0;
			predicted_cnt <= 0;
			accepted_cnt <= 0;
			wait_left = 0;
			wait_set = 1'b0;
		end else begin
			produced = 0;
			go = start;
			if (start && !busy) begin
				produced = apply_deque_op(operation, value);
				accepted_cnt <= accepted_cnt + 1;
				go = 1'b0;
			end
			// results still owed, counting the ones just predicted
			outstanding = predicted_cnt + produced - checked_cnt;
			if (!go && pending_ops.size() != 0) begin
				if (!wait_set) begin
					wait_left = pending_ops[0].gap;
					wait_set = 1'b1;
				end
				if (wait_left > 0) begin
					wait_left--;
				end else if (!pending_ops[0].drain || outstanding == 0) begin
					nxt = pending_ops.pop_front();
					operation <= nxt.op;
					value <= nxt.val;
					go = 1'b1;
					wait_set = 1'b0;
				end
			end
			// single write of start per edge, so a held item never glitches low
			start <= go;
			predicted_cnt <= predicted_cnt + produced;
		end
	end

	// ---------------------------------------------------------------
	// monitor: every strobed result is checked against the oldest prediction
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : check_results
		result_t want;
		if (!arst_n) begin
			checked_cnt <= 0;
		end else if (strobe) begin
			if (checked_cnt == predicted_cnt) begin
				$error("unexpected result: status %0d data %0d position %0d entries %0d last %0d",
					status, data, position, entries, last);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				checked_cnt <= checked_cnt + 1;
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					mismatches++;
				end
				if (data !== want.data) begin
					$error("data: expected %0d, actual %0d", want.data, data);
					mismatches++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, actual %0d", want.position, position);
					mismatches++;
				end
				if (entries !== want.entries) begin
					$error("entries: expected %0d, actual %0d", want.entries, entries);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	// queues one item; tracks the fill level so episodes can aim at full and empty
	function automatic void queue_op(logic [2:0] op, logic signed [31:0] val);
		op_item_t it;
		it.op    = op;
		it.val   = val;
		it.gap   = ep_burst ? 0 : $urandom_range(0, 9);
		it.drain = hold_next;
		hold_next = 1'b0;
		pending_ops.push_back(it);
		if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_fill < DEPTH)
			gen_fill++;
		else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_fill > 0)
			gen_fill--;
	endfunction

	// mostly values from a small pool so searches hit, and repeat entries
	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_push();
		return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
	endfunction

	function automatic logic [2:0] pick_pop();
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	initial begin : run_test
		int i;
		int n;
		int r;
		int idle_cycles;
		value_pool[0] = 32'sh7FFF_FFFF;
		value_pool[1] = 32'sh8000_0000;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		for (i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		// directed: empty cases first
		queue_op(OP_DUMP, 32'sh5A5A_A5A5);
		queue_op(OP_SEARCH, '0);
		queue_op(OP_POP_FRONT, -32'sd1);
		queue_op(OP_POP_BACK, '0);
		// extremes of the value field, from both ends
		queue_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		queue_op(OP_PUSH_BACK, 32'sh8000_0000);
		queue_op(OP_PUSH_FRONT, '0);
		queue_op(OP_PUSH_BACK, -32'sd1);
		queue_op(OP_PUSH_BACK, '0);
		// first match wins over the duplicate at the back
		queue_op(OP_SEARCH, '0);
		queue_op(OP_SEARCH, 32'sh8000_0000);
		// match on the back entry
		queue_op(OP_POP_BACK, '0);
		queue_op(OP_SEARCH, -32'sd1);
		queue_op(OP_SEARCH, 32'sd12345);
		queue_op(OP_DUMP, '0);
		// undefined codes are ignored
		queue_op(3'd6, -32'sd1);
		queue_op(3'd7, 32'sh8000_0000);
		queue_op(OP_POP_FRONT, '0);
		queue_op(OP_POP_BACK, '0);
		queue_op(OP_DUMP, '0);
		queue_op(OP_POP_FRONT, '0);
		queue_op(OP_POP_BACK, '0);
		queue_op(OP_DUMP, '0);

		// random episodes: fill to full, drain to empty, or a random mix
		hold_next = 1'b1;
		while (pending_ops.size() < TOTAL_OPS) begin
			ep_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				hold_next = 1'b1;
			case ($urandom_range(0, 2))
				0: begin
					while (gen_fill < DEPTH)
						queue_op(pick_push(), pick_value());
					n = $urandom_range(1, 2);
					for (i = 0; i < n; i++)
						queue_op(pick_push(), pick_value());
					queue_op(OP_SEARCH, pick_value());
					queue_op(OP_DUMP, $urandom);
				end
				1: begin
					while (gen_fill > 0)
						queue_op(pick_pop(), $urandom);
					n = $urandom_range(1, 2);
					for (i = 0; i < n; i++)
						queue_op(pick_pop(), $urandom);
					queue_op(OP_SEARCH, pick_value());
					queue_op(OP_DUMP, $urandom);
				end
				default: begin
					n = $urandom_range(10, 20);
					for (i = 0; i < n; i++) begin
						r = $urandom_range(0, 19);
						if (r < 8)
							queue_op(pick_push(), pick_value());
						else if (r < 13)
							queue_op(pick_pop(), $urandom);
						else if (r < 17)
							queue_op(OP_SEARCH, pick_value());
						else if (r < 19)
							queue_op(OP_DUMP, $urandom);
						else
							queue_op(3'($urandom_range(6, 7)), $urandom);
					end
				end
			endcase
		end
		total_items = pending_ops.size();

		// reset once, released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every item to be taken and every result to be checked
		idle_cycles = 0;
		while (!(accepted_cnt == total_items && predicted_cnt == checked_cnt)
			&& idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || strobe)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		if (idle_cycles < IDLE_LIMIT)
			repeat (TAIL_CYCLES) @(posedge clk);

		if (idle_cycles < IDLE_LIMIT && mismatches == 0 && predicted_cnt == checked_cnt)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
